### hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon crossing test.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    localparam int FIELD_W       = 32;
    localparam int COORD_W_DEF   = 32;
    localparam int COUNT_W       = 2;
    localparam int MIN_VERTICES  = 3;

    typedef logic [COUNT_W-1:0] t_vcount;

    typedef struct packed {
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic signed [FIELD_W-1:0] vert_x;
        logic signed [FIELD_W-1:0] vert_y;
        logic                      last_vert;
    } t_pip_in;

    typedef struct packed {
        logic is_inside;
        logic too_few_vertices;
    } t_pip_out;

endpackage

`default_nettype wire

### hdl/pip_if.sv
// ----------------------------------------------------------------------------
// pip_if
// Valid/ready channels that carry vertex words in and result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_in_if;
    import pip_pkg::*;

    logic    valid;
    logic    ready;
    t_pip_in data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pip_out_if;
    import pip_pkg::*;

    logic     valid;
    logic     ready;
    t_pip_out data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/point_in_polygon_crossing.sv
// The last vertex word is held in r_a, then its result word is registered in r_out.
// Unstalled, one vertex word per cycle; both edge tests of a vertex run in the same cycle.
// The input stalls only while a finished result waits in the result register.
// Reset: synchronous, active low; clears the valid flags, the vertex count and the parity.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// point_in_polygon_crossing
// Even-odd ray-casting test of a query point against a polygon streamed one
// vertex per word, with one result word per polygon.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_crossing #(
    parameter int COORD_WIDTH = pip_pkg::COORD_W_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pip_in_if.sink     i_vtx,
    pip_out_if.source  o_res
);
    import pip_pkg::*;

    localparam int W = COORD_WIDTH;

    logic                r_a_valid;
    t_pip_in             r_a;
    logic                r_out_valid;
    t_pip_out            r_out;

    logic signed [W-1:0] r_first_x;
    logic signed [W-1:0] r_first_y;
    logic signed [W-1:0] r_prev_x;
    logic signed [W-1:0] r_prev_y;
    logic signed [W-1:0] r_q_x;
    logic signed [W-1:0] r_q_y;
    logic                r_parity;
    t_vcount             r_count;

    logic                n_parity;
    t_vcount             n_count;
    t_pip_out            n_out;

    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic                first;
    logic                cross_prev;
    logic                cross_close;
    logic                out_free;
    logic                a_go;
    logic                in_ready;
    logic                par_mid;
    t_vcount             cnt_mid;
    logic                too_few;

    assign vx    = r_a.vert_x[W-1:0];
    assign vy    = r_a.vert_y[W-1:0];
    assign first = (r_count == '0);

    pip_edge_test #(.COORD_WIDTH(W)) u_edge_prev (
        .i_xi    (vx),
        .i_yi    (vy),
        .i_xj    (r_prev_x),
        .i_yj    (r_prev_y),
        .i_qx    (r_q_x),
        .i_qy    (r_q_y),
        .o_cross (cross_prev)
    );

    pip_edge_test #(.COORD_WIDTH(W)) u_edge_close (
        .i_xi    (r_first_x),
        .i_yi    (r_first_y),
        .i_xj    (vx),
        .i_yj    (vy),
        .i_qx    (r_q_x),
        .i_qy    (r_q_y),
        .o_cross (cross_close)
    );

    assign out_free    = !r_out_valid || o_res.ready;
    assign a_go        = r_a_valid && (!r_a.last_vert || out_free);
    assign in_ready    = !r_a_valid || a_go;
    assign i_vtx.ready = in_ready;

    always_comb begin
        if (first) begin
            par_mid = 1'b0;
            cnt_mid = t_vcount'(1);
        end else begin
            par_mid = r_parity ^ cross_prev;
            cnt_mid = (r_count < t_vcount'(MIN_VERTICES)) ? r_count + t_vcount'(1)
                                                          : r_count;
        end
        too_few                = (cnt_mid < t_vcount'(MIN_VERTICES));
        n_out.too_few_vertices = too_few;
        n_out.is_inside        = !too_few && (par_mid ^ cross_close);
        if (r_a.last_vert) begin
            n_parity = 1'b0;
            n_count  = '0;
        end else begin
            n_parity = par_mid;
            n_count  = cnt_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_parity    <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_ready) begin
                r_a_valid <= i_vtx.valid;
            end
            if (a_go) begin
                r_parity <= n_parity;
                r_count  <= n_count;
            end
            if (a_go && r_a.last_vert) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_vtx.valid) begin
            r_a <= i_vtx.data;
        end
        if (a_go) begin
            r_prev_x <= vx;
            r_prev_y <= vy;
            if (first) begin
                r_first_x <= vx;
                r_first_y <= vy;
                r_q_x     <= r_a.point_x[W-1:0];
                r_q_y     <= r_a.point_y[W-1:0];
            end
        end
        if (a_go && r_a.last_vert) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
endmodule

`default_nettype wire

### hdl/pip_edge_test.sv
// ----------------------------------------------------------------------------
// pip_edge_test
// Tests whether the edge from (xj, yj) to (xi, yi) crosses the rightward
// horizontal ray from the query point, with an exact cross-multiplied compare.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge_test #(
    parameter int COORD_WIDTH = pip_pkg::COORD_W_DEF
) (
    input  wire logic signed [COORD_WIDTH-1:0] i_xi,
    input  wire logic signed [COORD_WIDTH-1:0] i_yi,
    input  wire logic signed [COORD_WIDTH-1:0] i_xj,
    input  wire logic signed [COORD_WIDTH-1:0] i_yj,
    input  wire logic signed [COORD_WIDTH-1:0] i_qx,
    input  wire logic signed [COORD_WIDTH-1:0] i_qy,
    output logic                               o_cross
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [DW-1:0] dqx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dqy;
    logic signed [PW-1:0] lhs;
    logic signed [PW-1:0] rhs;
    logic signed [SW-1:0] diff;
    logic                 straddle;
    logic                 dy_pos;
    logic                 diff_pos;

    assign dqx = {i_qx[COORD_WIDTH-1], i_qx} - {i_xi[COORD_WIDTH-1], i_xi};
    assign dy  = {i_yj[COORD_WIDTH-1], i_yj} - {i_yi[COORD_WIDTH-1], i_yi};
    assign dx  = {i_xj[COORD_WIDTH-1], i_xj} - {i_xi[COORD_WIDTH-1], i_xi};
    assign dqy = {i_qy[COORD_WIDTH-1], i_qy} - {i_yi[COORD_WIDTH-1], i_yi};

    assign lhs  = dqx * dy;
    assign rhs  = dx * dqy;
    assign diff = {lhs[PW-1], lhs} - {rhs[PW-1], rhs};

    assign straddle = (i_yi > i_qy) != (i_yj > i_qy);
    assign dy_pos   = !dy[DW-1] && (dy != '0);
    assign diff_pos = !diff[SW-1] && (diff != '0);

    always_comb begin
        if (!straddle) begin
            o_cross = 1'b0;
        end else if (dy_pos) begin
            o_cross = diff[SW-1];
        end else begin
            o_cross = diff_pos;
        end
    end
endmodule

`default_nettype wire

### hdl/pip_checker.sv
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks of the point-in-polygon crossing test, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_in_last,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire pip_pkg::t_pip_out i_out_data
);
    import pip_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_few_not_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.too_few_vertices |-> !i_out_data.is_inside)
        else $error("short polygon reported inside");

    a_stall_only_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled with no waiting result");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result word changed");

    a_mid_word_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_last |=> i_in_ready)
        else $error("stall after a word that makes no result");
endmodule

bind point_in_polygon_crossing pip_checker u_pip_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vtx.valid),
    .i_in_ready  (i_vtx.ready),
    .i_in_last   (i_vtx.data.last_vert),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the point-in-polygon crossing test. Polygons go in
// one vertex word at a time: hand-picked shapes first (too few vertices,
// inside, outside, point on an edge and on a vertex, horizontal edges, full
// scale coordinates), then random polygons on coarse grids, medium and wide
// ranges and extreme values. A bit-exact even-odd predictor folds every
// accepted vertex word and queues the verdict that a closing vertex must
// produce. Every result word is checked field by field against that queue.
// Both handshakes stall at random outside a steady stretch of accepted words.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam int COORD_W      = COORD_W_DEF;
    localparam int DIRECTED_CNT = 25;
    localparam int RANDOM_CNT   = 650;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int TAIL_CYCLES  = 8;

    typedef enum int unsigned {
        COORD_GRID,
        COORD_WIDE,
        COORD_EXTREME,
        COORD_MEDIUM
    } t_coord_style;

    typedef struct {
        t_pip_in word;
        bit      drain;
    } t_vertex_job;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pip_in_if  vtx ();
    pip_out_if res ();

    point_in_polygon_crossing #(
        .COORD_WIDTH (COORD_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx),
        .o_res   (res)
    );

    t_vertex_job vertex_backlog[$];
    t_pip_out    expected_verdicts[$];
    int          words_queued = 0;
    int          words_taken  = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    logic        steady;

    logic signed [31:0] first_vx = '0;
    logic signed [31:0] first_vy = '0;
    logic signed [31:0] prev_vx  = '0;
    logic signed [31:0] prev_vy  = '0;
    logic signed [31:0] held_qx  = '0;
    logic signed [31:0] held_qy  = '0;
    bit                 parity   = 1'b0;
    int                 vert_seen = 0;

    assign steady = (words_taken >= 300) && (words_taken < 420);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] coord_of(input logic [31:0] raw);
        logic signed [31:0] v;
        v = raw << (32 - COORD_W);
        return v >>> (32 - COORD_W);
    endfunction

    function automatic bit edge_crosses(input logic signed [31:0] xi, yi, xj, yj);
        logic signed [67:0] dy;
        logic signed [67:0] lhs;
        logic signed [67:0] rhs;
        if ((yi > held_qy) == (yj > held_qy)) begin
            return 1'b0;
        end
        dy  = yj - yi;
        lhs = (held_qx - xi) * dy;
        rhs = (xj - xi) * (held_qy - yi);
        return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic void fold_vertex(input t_pip_in w, output bit has_verdict,
                                        output t_pip_out verdict);
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        vx          = coord_of(w.vert_x);
        vy          = coord_of(w.vert_y);
        has_verdict = 1'b0;
        verdict     = '0;
        if (vert_seen == 0) begin
            held_qx   = coord_of(w.point_x);
            held_qy   = coord_of(w.point_y);
            first_vx  = vx;
            first_vy  = vy;
            parity    = 1'b0;
            vert_seen = 1;
        end else begin
            parity ^= edge_crosses(vx, vy, prev_vx, prev_vy);
            if (vert_seen < MIN_VERTICES) begin
                vert_seen++;
            end
        end
        prev_vx = vx;
        prev_vy = vy;
        if (w.last_vert) begin
            has_verdict = 1'b1;
            if (vert_seen < MIN_VERTICES) begin
                verdict.too_few_vertices = 1'b1;
            end else begin
                parity ^= edge_crosses(first_vx, first_vy, vx, vy);
                verdict.is_inside = parity;
            end
            parity    = 1'b0;
            vert_seen = 0;
        end
    endfunction

    function automatic logic [31:0] q16(input int v);
        return 32'(v) << 16;
    endfunction

    function automatic logic [31:0] pick_coord(input t_coord_style style);
        case (style)
            COORD_GRID:   return q16(int'($urandom_range(8)) - 4);
            COORD_WIDE:   return $urandom();
            COORD_MEDIUM: return 32'(int'($urandom_range(200)) - 100) << 12;
            default: begin
                case ($urandom_range(5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    3:       return 32'hffff_ffff;
                    4:       return 32'h0000_0001;
                    default: return $urandom();
                endcase
            end
        endcase
    endfunction

    task automatic add_vertex(input logic [31:0] qx, qy, vx, vy, input bit last,
                              input bit drain);
        t_vertex_job job;
        job.word.point_x   = qx;
        job.word.point_y   = qy;
        job.word.vert_x    = vx;
        job.word.vert_y    = vy;
        job.word.last_vert = last;
        job.drain          = drain;
        vertex_backlog.push_back(job);
        words_queued++;
    endtask

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : drive_vertices
        t_vertex_job job;
        if (!i_rst_n) begin
            vtx.valid <= 1'b0;
            vtx.data  <= '0;
        end else if (!vtx.valid || vtx.ready) begin
            if (vertex_backlog.size() == 0 || (!steady && $urandom_range(99) < 36)) begin
                vtx.valid <= 1'b0;
            end else if (vertex_backlog[0].drain &&
                         (vtx.valid || expected_verdicts.size() != 0)) begin
                vtx.valid <= 1'b0;
            end else begin
                job = vertex_backlog.pop_front();
                vtx.valid <= 1'b1;
                vtx.data  <= job.word;
            end
        end
    end

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            res.ready <= steady || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge i_clk) begin : check_verdicts
        bit       has_verdict;
        t_pip_out predicted;
        t_pip_out wanted;
        if (i_rst_n) begin
            if (vtx.valid && vtx.ready) begin
                fold_vertex(vtx.data, has_verdict, predicted);
                if (has_verdict) begin
                    expected_verdicts.push_back(predicted);
                end
                words_taken++;
            end
            if (res.valid && res.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %b", res.data));
                end else begin
                    wanted = expected_verdicts.pop_front();
                    if (res.data.is_inside !== wanted.is_inside) begin
                        report_mismatch($sformatf("is_inside %b, expected %b",
                                                  res.data.is_inside, wanted.is_inside));
                    end
                    if (res.data.too_few_vertices !== wanted.too_few_vertices) begin
                        report_mismatch($sformatf("too_few_vertices %b, expected %b",
                                                  res.data.too_few_vertices,
                                                  wanted.too_few_vertices));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        t_coord_style style;
        logic [31:0]  qx;
        logic [31:0]  qy;
        int           n;
        int           poly;

        vtx.valid = 1'b0;
        vtx.data  = '0;
        res.ready = 1'b0;

        add_vertex(q16(1), q16(1), q16(0), q16(0), 1'b1, 1'b0);

        add_vertex(q16(0), q16(0), q16(-1), q16(-1), 1'b0, 1'b0);
        add_vertex($urandom(), $urandom(), q16(2), q16(2), 1'b1, 1'b0);

        add_vertex(q16(0), q16(0), q16(-4), q16(-4), 1'b0, 1'b0);
        add_vertex($urandom(), $urandom(), q16(4), q16(-4), 1'b0, 1'b0);
        add_vertex($urandom(), $urandom(), q16(0), q16(4), 1'b1, 1'b0);

        add_vertex(q16(6), q16(0), q16(-2), q16(-2), 1'b0, 1'b0);
        add_vertex(q16(0), q16(0), q16(2), q16(-2), 1'b0, 1'b0);
        add_vertex(q16(0), q16(0), q16(2), q16(2), 1'b0, 1'b0);
        add_vertex(q16(0), q16(0), q16(-2), q16(2), 1'b1, 1'b0);

        // The point sits on the left edge, and the ray runs along no edge.
        add_vertex(q16(-2), q16(0), q16(-2), q16(-2), 1'b0, 1'b0);
        add_vertex(q16(0), q16(0), q16(2), q16(-2), 1'b0, 1'b0);
        add_vertex(q16(0), q16(0), q16(2), q16(2), 1'b0, 1'b0);
        add_vertex(q16(0), q16(0), q16(-2), q16(2), 1'b1, 1'b0);

        // Opposite winding, with the point on a corner and on the top edge's line.
        add_vertex(q16(2), q16(2), q16(-2), q16(-2), 1'b0, 1'b0);
        add_vertex(q16(0), q16(0), q16(-2), q16(2), 1'b0, 1'b0);
        add_vertex(q16(0), q16(0), q16(2), q16(2), 1'b0, 1'b0);
        add_vertex(q16(0), q16(0), q16(2), q16(-2), 1'b1, 1'b0);

        add_vertex(32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0);
        add_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0);
        add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0);
        add_vertex(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);

        add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0);
        add_vertex(32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0);
        add_vertex(32'h0, 32'h0, 32'h0000_0000, 32'h7fff_ffff, 1'b1, 1'b0);

        poly = 0;
        while (words_queued < DIRECTED_CNT + RANDOM_CNT) begin
            style = t_coord_style'($urandom_range(3));
            n     = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            qx    = pick_coord(style);
            qy    = pick_coord(style);
            for (int k = 0; k < n; k++) begin
                add_vertex((k == 0) ? qx : $urandom(), (k == 0) ? qy : $urandom(),
                           pick_coord(style), pick_coord(style), k == n - 1,
                           (k == 0) && (poly % 25 == 0));
            end
            poly++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_taken != words_queued) begin
            @(posedge i_clk);
        end
        while (expected_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### point_in_polygon_crossing.f
hdl/pip_pkg.sv
hdl/pip_if.sv
hdl/pip_edge_test.sv
hdl/point_in_polygon_crossing.sv
hdl/pip_checker.sv
dv/tb.sv
